[src/antialiased_line_rasterizer_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the antialiased line rasterizer
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ANTIALIASED_LINE_RASTERIZER_CORE_ASSERT_SVH
`define ANTIALIASED_LINE_RASTERIZER_CORE_ASSERT_SVH

// same-cycle implication
`define AALR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AALR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/aalr_pkg.sv]
// ---------------------------------------------------------------------------
// aalr_pkg
// Shared constants, controller states and command/status bundles.
// ---------------------------------------------------------------------------
package aalr_pkg;

	localparam int COORD_FRAC_BITS     = 6;
	localparam int SLOPE_FRAC_BITS     = 16;
	localparam int INTENSITY_FRAC_BITS = 8;
	localparam int MAX_SCREEN_DIM      = 4096;

	localparam int DIV_STEPS = SLOPE_FRAC_BITS + 1;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_NEXT = 1'b1;

	localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;

	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_INNER  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SLOPE,
		ST_EP0,
		ST_EP1,
		ST_SHADE
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic slope;
		logic ep0;
		logic ep1;
		logic col;
		logic shade;
	} cmd_t;

	typedef struct packed {
		logic line_active;
		logic div_last;
		logic out_busy;
	} sts_t;

endpackage

[src/aalr_ctrl.sv]
// ---------------------------------------------------------------------------
// aalr_ctrl
// Sequencer: load, division steps, endpoint setup, column shading.
// ---------------------------------------------------------------------------
module aalr_ctrl import aalr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  logic   opcode,
	input  sts_t   sts,
	output logic   in_stall,
	output cmd_t   cmd,
	output state_t state
);

	state_t state_q, state_d;
	logic   accept;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign state    = state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && opcode == OP_LOAD) begin
					state_d = ST_DIV;
				end else if (accept && sts.line_active) begin
					state_d = ST_SHADE;
				end
			end
			ST_DIV: begin
				if (sts.div_last) begin
					state_d = ST_SLOPE;
				end
			end
			ST_SLOPE: state_d = ST_EP0;
			ST_EP0:   state_d = ST_EP1;
			ST_EP1:   state_d = ST_IDLE;
			ST_SHADE: begin
				if (!sts.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.load     = accept && (opcode == OP_LOAD);
		cmd.col      = accept && (opcode == OP_NEXT) && sts.line_active;
		cmd.div_step = (state_q == ST_DIV);
		cmd.slope    = (state_q == ST_SLOPE);
		cmd.ep0      = (state_q == ST_EP0);
		cmd.ep1      = (state_q == ST_EP1);
		cmd.shade    = (state_q == ST_SHADE) && !sts.out_busy;
	end

endmodule

[src/aalr_dp.sv]
// ---------------------------------------------------------------------------
// aalr_dp
// Datapath: setup, gradient divider, endpoint terms, column stepping,
// shading, screen mapping and the output register.
// ---------------------------------------------------------------------------
module aalr_dp import aalr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic signed [17:0] start_x,
	input  logic signed [17:0] start_y,
	input  logic signed [17:0] end_x,
	input  logic signed [17:0] end_y,
	input  logic [23:0]        line_color,
	input  logic               cfg_valid,
	input  logic [1:0]         cfg_index,
	input  logic [12:0]        cfg_data,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [11:0]        upper_x,
	output logic [11:0]        upper_y,
	output logic [31:0]        upper_argb,
	output logic               upper_visible,
	output logic [11:0]        lower_x,
	output logic [11:0]        lower_y,
	output logic [31:0]        lower_argb,
	output logic               lower_visible,
	output logic               last_column
);

	typedef struct packed {
		logic signed [12:0] col;
		logic signed [28:0] yq;
		logic [6:0]         gap;
	} ep_t;

	function automatic ep_t endpoint_f(input logic signed [17:0] xq,
		input logic signed [17:0] yin, input logic signed [17:0] slope, input logic second);
		ep_t                r;
		logic [18:0]        mag;
		logic signed [12:0] xe;
		logic signed [19:0] dfull;
		logic signed [6:0]  d;
		logic signed [24:0] prod;
		logic [5:0]         frac;
		if (!xq[17]) begin
			mag = 19'(xq) + 19'd32;
			xe  = 13'(mag >> COORD_FRAC_BITS);
		end else begin
			mag = 19'(-20'(xq)) + 19'd32;
			xe  = -13'(mag >> COORD_FRAC_BITS);
		end
		dfull = (20'(xe) <<< COORD_FRAC_BITS) - 20'(xq);
		d     = dfull[6:0];
		prod  = 25'(slope) * 25'(d);
		frac  = xq[5:0] + 6'd32;
		r.col = xe;
		r.yq  = (29'(yin) <<< (SLOPE_FRAC_BITS - COORD_FRAC_BITS)) + 29'(prod >>> COORD_FRAC_BITS);
		r.gap = second ? {1'b0, frac} : (7'd64 - {1'b0, frac});
		return r;
	endfunction

	function automatic logic [31:0] shade_f(input logic [23:0] c, input logic [8:0] i);
		logic [31:0] res;
		logic [16:0] p;
		logic [8:0]  s;
		res = 32'hFF00_0000;
		for (int k = 0; k < 3; k++) begin
			p = 17'(c[k*8 +: 8]) * 17'(i);
			s = 9'(p >> INTENSITY_FRAC_BITS);
			res[k*8 +: 8] = s[8] ? 8'hFF : s[7:0];
		end
		return res;
	endfunction

	// configuration
	logic [12:0] width_q, height_q, cfg_clamped;
	assign cfg_clamped = (cfg_data > 13'(MAX_SCREEN_DIM)) ? 13'(MAX_SCREEN_DIM) : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd640;
			height_q <= 13'd480;
		end else if (cfg_valid) begin
			if (cfg_index == REG_SCREEN_WIDTH) width_q <= cfg_clamped;
			if (cfg_index == REG_SCREEN_HEIGHT) height_q <= cfg_clamped;
		end
	end

	// load setup
	logic signed [18:0] ddx, ddy, oax, oay, obx, oby, dx_l, dy_l;
	logic [18:0]        adx, ady, ady_o;
	logic               steep_l, swap_l;
	logic signed [17:0] a0x, a0y, b0x, b0y;
	logic [36:0]        num_l;

	always_comb begin
		ddx     = 19'(end_x) - 19'(start_x);
		ddy     = 19'(end_y) - 19'(start_y);
		adx     = ddx[18] ? 19'(-ddx) : 19'(ddx);
		ady     = ddy[18] ? 19'(-ddy) : 19'(ddy);
		steep_l = ady > adx;
		a0x     = steep_l ? start_y : start_x;
		a0y     = steep_l ? start_x : start_y;
		b0x     = steep_l ? end_y : end_x;
		b0y     = steep_l ? end_x : end_y;
		swap_l  = a0x > b0x;
		oax     = 19'(swap_l ? b0x : a0x);
		oay     = 19'(swap_l ? b0y : a0y);
		obx     = 19'(swap_l ? a0x : b0x);
		oby     = 19'(swap_l ? a0y : b0y);
		dx_l    = obx - oax;
		dy_l    = oby - oay;
		ady_o   = dy_l[18] ? 19'(-dy_l) : 19'(dy_l);
		num_l   = {1'b0, ady_o, 17'b0} + 37'(dx_l);
	end

	logic signed [17:0] ax_q, ay_q, bx_q, by_q, slope_q;
	logic [19:0]        den_q, rem_q;
	logic [16:0]        nsh_q, quo_q;
	logic [4:0]         cnt_q;
	logic               dyneg_q, dxzero_q, steep_q;
	logic [23:0]        color_q;

	// divider step
	logic [20:0] trial;
	logic        ge;
	assign trial = {rem_q, nsh_q[16]};
	assign ge    = trial >= {1'b0, den_q};

	ep_t ep_sel, ep0_q, ep1_q;
	assign ep_sel = endpoint_f(cmd.ep0 ? ax_q : bx_q, cmd.ep0 ? ay_q : by_q, slope_q, cmd.ep1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ax_q     <= oax[17:0];
			ay_q     <= oay[17:0];
			bx_q     <= obx[17:0];
			by_q     <= oby[17:0];
			steep_q  <= steep_l;
			dyneg_q  <= dy_l[18];
			dxzero_q <= (dx_l == '0);
			den_q    <= {dx_l[18:0], 1'b0};
			rem_q    <= num_l[36:17];
			nsh_q    <= num_l[16:0];
			color_q  <= line_color;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? 20'(trial - {1'b0, den_q}) : trial[19:0];
			nsh_q <= {nsh_q[15:0], 1'b0};
			quo_q <= {quo_q[15:0], ge};
		end
		if (cmd.slope) begin
			slope_q <= dxzero_q ? 18'sd65536 : (dyneg_q ? -18'(quo_q) : 18'(quo_q));
		end
		if (cmd.ep0) begin
			ep0_q <= ep_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= 5'(DIV_STEPS);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	// column stepping
	logic               active_q;
	logic [1:0]         phase_q;
	logic signed [12:0] cursor_q, limit_q;
	logic signed [28:0] run_q;
	logic signed [13:0] cur_next;
	assign cur_next = 14'(cursor_q) + 14'sd1;

	ep_t                cs;
	logic               last_c;
	logic [15:0]        fy;
	logic [16:0]        rf;
	logic [23:0]        pu;
	logic [22:0]        pl;

	always_comb begin
		unique case (phase_q)
			PH_FIRST: begin
				cs     = ep0_q;
				last_c = 1'b0;
			end
			PH_SECOND: begin
				cs     = ep1_q;
				last_c = cursor_q >= limit_q;
			end
			default: begin
				cs.col = cursor_q;
				cs.yq  = run_q;
				cs.gap = 7'(1 << COORD_FRAC_BITS);
				last_c = cur_next >= 14'(limit_q);
			end
		endcase
		fy = cs.yq[15:0];
		rf = 17'(1 << SLOPE_FRAC_BITS) - {1'b0, fy};
		pu = 24'(rf) * 24'(cs.gap);
		pl = 23'(fy) * 23'(cs.gap);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			phase_q  <= PH_FIRST;
		end else if (cmd.load) begin
			active_q <= 1'b0;
			phase_q  <= PH_FIRST;
		end else if (cmd.ep1) begin
			active_q <= 1'b1;
		end else if (cmd.col) begin
			if (phase_q == PH_FIRST) begin
				phase_q <= PH_SECOND;
			end else if (last_c) begin
				active_q <= 1'b0;
			end else begin
				phase_q <= PH_INNER;
			end
		end
	end

	logic [8:0]         iu_s1, il_s1;
	logic signed [12:0] col_s1, ip_s1;
	logic               last_s1;

	always_ff @(posedge clk) begin
		if (cmd.ep1) begin
			ep1_q    <= ep_sel;
			limit_q  <= ep_sel.col;
			cursor_q <= ep0_q.col + 13'sd1;
			run_q    <= ep0_q.yq + 29'(slope_q);
		end else if (cmd.col && phase_q == PH_INNER) begin
			cursor_q <= cur_next[12:0];
			run_q    <= run_q + 29'(slope_q);
		end
		if (cmd.col) begin
			iu_s1   <= 9'(pu >> (SLOPE_FRAC_BITS + COORD_FRAC_BITS - INTENSITY_FRAC_BITS));
			il_s1   <= 9'(pl >> (SLOPE_FRAC_BITS + COORD_FRAC_BITS - INTENSITY_FRAC_BITS));
			col_s1  <= cs.col;
			ip_s1   <= cs.yq[28:16];
			last_s1 <= last_c;
		end
	end

	// screen mapping
	logic signed [13:0] row_u, row_l, colw;
	logic signed [14:0] sxu, syu, sxl, syl, hw, hh, wd, ht;

	always_comb begin
		row_u = 14'(ip_s1);
		row_l = row_u + 14'sd1;
		colw  = 14'(col_s1);
		hw    = $signed({3'b0, width_q[12:1]});
		hh    = $signed({3'b0, height_q[12:1]});
		wd    = $signed({2'b0, width_q});
		ht    = $signed({2'b0, height_q});
		sxu   = 15'(steep_q ? row_u : colw) + hw;
		syu   = hh - 15'(steep_q ? colw : row_u);
		sxl   = 15'(steep_q ? row_l : colw) + hw;
		syl   = hh - 15'(steep_q ? colw : row_l);
	end

	logic ov_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.shade) begin
			ov_q <= 1'b1;
		end else if (!out_stall) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shade) begin
			upper_x       <= sxu[11:0];
			upper_y       <= syu[11:0];
			upper_argb    <= shade_f(color_q, iu_s1);
			upper_visible <= !sxu[14] && sxu < wd && !syu[14] && syu < ht;
			lower_x       <= sxl[11:0];
			lower_y       <= syl[11:0];
			lower_argb    <= shade_f(color_q, il_s1);
			lower_visible <= !sxl[14] && sxl < wd && !syl[14] && syl < ht;
			last_column   <= last_s1;
		end
	end

	assign out_valid       = ov_q;
	assign sts.line_active = active_q;
	assign sts.div_last    = (cnt_q == 5'd1);
	assign sts.out_busy    = ov_q && out_stall;

endmodule

[src/antialiased_line_rasterizer_core.sv]
// ---------------------------------------------------------------------------
// antialiased_line_rasterizer_core
// Antialiased line rasterizer: one load per line, then one column per request.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_stall): opcode 0 loads a line with its color,
// opcode 1 requests the next column. A load produces no output; a request
// with no line in progress is taken and dropped.
// Output channel (out_valid/out_stall): one transfer per column, carrying
// the upper and lower pixel with scaled color and visible flags, and
// last_column on the final one.
// Configuration channel (cfg_valid/cfg_ready): screen width (index 0) and
// height (index 1); cfg_ready is always high. Write only while idle.
// Load: the input stays stalled through the one-bit-a-cycle gradient
// divider, the slope sign step and the two endpoint term steps.
// Column request: coverage is registered in the accept cycle; shading and
// screen mapping then go into the output register in the shading step,
// which waits while the receiver stalls with the previous column held.
// If the receiver stalls, hold the finished column in the output register;
// the block takes one more request and then waits in its shading step.
// Reset clears the sequencer, drops any line and sets 640 x 480.
// ---------------------------------------------------------------------------
module antialiased_line_rasterizer_core import aalr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               opcode,
	input  logic signed [17:0] start_x,
	input  logic signed [17:0] start_y,
	input  logic signed [17:0] end_x,
	input  logic signed [17:0] end_y,
	input  logic [23:0]        line_color,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [11:0]        upper_x,
	output logic [11:0]        upper_y,
	output logic [31:0]        upper_argb,
	output logic               upper_visible,
	output logic [11:0]        lower_x,
	output logic [11:0]        lower_y,
	output logic [31:0]        lower_argb,
	output logic               lower_visible,
	output logic               last_column,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [12:0]        cfg_data
);

	`include "antialiased_line_rasterizer_core_assert.svh"

	cmd_t   cmd;
	sts_t   sts;
	state_t state;

	// configuration writes are always accepted; cfg_ready is tied high
	assign cfg_ready = 1'b1;

	aalr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd),
		.state    (state)
	);

	aalr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.start_x       (start_x),
		.start_y       (start_y),
		.end_x         (end_x),
		.end_y         (end_y),
		.line_color    (line_color),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.upper_x       (upper_x),
		.upper_y       (upper_y),
		.upper_argb    (upper_argb),
		.upper_visible (upper_visible),
		.lower_x       (lower_x),
		.lower_y       (lower_y),
		.lower_argb    (lower_argb),
		.lower_visible (lower_visible),
		.last_column   (last_column)
	);

	// shading must never overwrite a column the receiver still holds
	`AALR_ASSERT_NOW(a_no_overwrite, cmd.shade, !(out_valid && out_stall), "column overwritten")
	// a load never yields a column transfer directly after it
	`AALR_ASSERT_NXT(a_load_silent, cmd.load, state == ST_DIV && !cmd.shade, "load produced output")
	// a taken column request always enters the shading step next
	`AALR_ASSERT_NXT(a_col_shades, cmd.col, state == ST_SHADE, "column request lost")

endmodule

[tb/sv/tb_antialiased_line_rasterizer_core.sv]
// ---------------------------------------------------------------------------
// tb_antialiased_line_rasterizer_core
// Self-checking bench for the Wu line rasterizer: directed rows, then random
// lines with random column requests, checked against a fixed-point predictor.
// ---------------------------------------------------------------------------
module tb_antialiased_line_rasterizer_core;
	timeunit 1ns;
	timeprecision 1ps;
	import aalr_pkg::*;

	localparam int LIMIT_CYCLES = 600000;
	localparam int SETTLE       = 40;
	localparam int N_RANDOM     = 1850;

	logic clk, arst_n;
	logic in_valid, in_stall, opcode;
	logic signed [17:0] start_x, start_y, end_x, end_y;
	logic [23:0] line_color;
	logic out_valid, out_stall;
	logic [11:0] upper_x, upper_y, lower_x, lower_y;
	logic [31:0] upper_argb, lower_argb;
	logic upper_visible, lower_visible, last_column;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [12:0] cfg_data;

	antialiased_line_rasterizer_core uut (.*);

	typedef struct packed {
		logic [11:0] ux, uy; logic [31:0] ua; logic uv;
		logic [11:0] lx, ly; logic [31:0] la; logic lv;
		logic lastc;
	} column_t;

	typedef struct {
		logic op;
		logic signed [17:0] sx, sy, ex, ey;
		logic [23:0] color;
		bit has_fixed;   // expected column typed in by hand
		column_t fixed;
	} stim_row_t;

	// predictor state
	bit        p_active, p_steep;
	int        p_phase;
	longint    p_ep[4];
	longint    p_slope, p_icept, p_cursor, p_limit;
	logic [23:0] p_color;
	longint    p_width, p_height;

	column_t   pending_columns[$];
	int        errors, cycles, columns_seen;
	int        in_idle_pct, out_idle_pct;
	bit        hold_sender;

	function automatic longint fshr(longint v, int k);
		return v >>> k;
	endfunction

	function automatic longint round_q6(longint v);
		if (v >= 0) return (v + 32) >>> COORD_FRAC_BITS;
		return -((-v + 32) >>> COORD_FRAC_BITS);
	endfunction

	function automatic logic [31:0] scale_color(logic [23:0] c, longint inten);
		logic [31:0] r;
		longint ch;
		r = 32'hFF000000;
		for (int s = 0; s < 24; s += 8) begin
			ch = (longint'(c[s +: 8]) * inten) >>> INTENSITY_FRAC_BITS;
			if (ch > 255) ch = 255;
			r[s +: 8] = ch[7:0];
		end
		return r;
	endfunction

	function automatic void map_pixel(input longint col, input longint row, input longint inten,
			output logic [11:0] x, output logic [11:0] y, output logic [31:0] a,
			output logic v);
		longint px, py, sx, sy;
		px = p_steep ? row : col;
		py = p_steep ? col : row;
		sx = px + p_width / 2;
		sy = p_height / 2 - py;
		x = sx[11:0];
		y = sy[11:0];
		a = scale_color(p_color, inten);
		v = sx >= 0 && sx < p_width && sy >= 0 && sy < p_height;
	endfunction

	function automatic void endpoint_terms(input int which, output longint col,
			output longint yq, output longint gap);
		longint xq, xe, d, fr;
		xq = p_ep[2 * which];
		xe = round_q6(xq);
		d = xe * 64 - xq;
		fr = (xq + 32) & 63;
		col = xe;
		yq = p_ep[2 * which + 1] * (1 << (SLOPE_FRAC_BITS - COORD_FRAC_BITS))
			+ fshr(p_slope * d, COORD_FRAC_BITS);
		gap = which == 0 ? 64 - fr : fr;
	endfunction

	function automatic column_t build_column(longint col, longint yq, longint gap,
			int gap_bits, bit lastc);
		column_t c;
		longint ip, fy, rf;
		int sh;
		ip = fshr(yq, SLOPE_FRAC_BITS);
		fy = yq - ip * (1 << SLOPE_FRAC_BITS);
		rf = (1 << SLOPE_FRAC_BITS) - fy;
		sh = SLOPE_FRAC_BITS + gap_bits - INTENSITY_FRAC_BITS;
		map_pixel(col, ip, (rf * gap) >> sh, c.ux, c.uy, c.ua, c.uv);
		map_pixel(col, ip + 1, (fy * gap) >> sh, c.lx, c.ly, c.la, c.lv);
		c.lastc = lastc;
		return c;
	endfunction

	// advance the predictor by one accepted item; return 1 with a column if any
	function automatic bit rasterize_item(input stim_row_t r, output column_t c);
		longint ax, ay, bx, by, t, dx, dy, num, q, col, yq, gap;
		bit lastc;
		c = '0;
		if (r.op == OP_LOAD) begin
			ax = r.sx; ay = r.sy; bx = r.ex; by = r.ey;
			p_steep = (by >= ay ? by - ay : ay - by) > (bx >= ax ? bx - ax : ax - bx);
			if (p_steep) begin
				t = ax; ax = ay; ay = t;
				t = bx; bx = by; by = t;
			end
			if (ax > bx) begin
				t = ax; ax = bx; bx = t;
				t = ay; ay = by; by = t;
			end
			dx = bx - ax;
			dy = by - ay;
			if (dx == 0) p_slope = 1 << SLOPE_FRAC_BITS;
			else begin
				num = (dy < 0 ? -dy : dy) * (1 << SLOPE_FRAC_BITS);
				q = (2 * num + dx) / (2 * dx);
				p_slope = dy < 0 ? -q : q;
			end
			p_ep[0] = ax; p_ep[1] = ay; p_ep[2] = bx; p_ep[3] = by;
			p_color = r.color;
			endpoint_terms(0, col, yq, gap);
			p_icept = yq + p_slope;
			p_cursor = col + 1;
			endpoint_terms(1, col, yq, gap);
			p_limit = col;
			p_phase = 0;
			p_active = 1;
			return 0;
		end
		if (!p_active) return 0;
		if (p_phase == 0) begin
			endpoint_terms(0, col, yq, gap);
			c = build_column(col, yq, gap, COORD_FRAC_BITS, 0);
			p_phase = 1;
			return 1;
		end
		if (p_phase == 1) begin
			endpoint_terms(1, col, yq, gap);
			lastc = p_cursor >= p_limit;
			c = build_column(col, yq, gap, COORD_FRAC_BITS, lastc);
			if (lastc) p_active = 0; else p_phase = 2;
			return 1;
		end
		col = p_cursor;
		yq = p_icept;
		p_cursor++;
		p_icept += p_slope;
		lastc = p_cursor >= p_limit;
		c = build_column(col, yq, 1, 0, lastc);
		if (lastc) p_active = 0;
		return 1;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint exp);
		$display("mismatch %s: got %0h expected %0h (column %0d)", what, got, exp,
			columns_seen);
		errors++;
	endtask

	// clock and cycle watchdog
	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_antialiased_line_rasterizer_core: FAIL");
			$finish;
		end
	end

	// receiver: random stall, compare each transfer with the oldest expectation
	always @(posedge clk) begin
		column_t e, g;
		if (arst_n && out_valid && !out_stall) begin
			g = '{upper_x, upper_y, upper_argb, upper_visible,
				lower_x, lower_y, lower_argb, lower_visible, last_column};
			if (pending_columns.size() == 0) begin
				report_mismatch("unexpected transfer", 1, 0);
			end else begin
				e = pending_columns.pop_front();
				if (g.ux !== e.ux) report_mismatch("upper_x", g.ux, e.ux);
				if (g.uy !== e.uy) report_mismatch("upper_y", g.uy, e.uy);
				if (g.ua !== e.ua) report_mismatch("upper_argb", g.ua, e.ua);
				if (g.uv !== e.uv) report_mismatch("upper_visible", g.uv, e.uv);
				if (g.lx !== e.lx) report_mismatch("lower_x", g.lx, e.lx);
				if (g.ly !== e.ly) report_mismatch("lower_y", g.ly, e.ly);
				if (g.la !== e.la) report_mismatch("lower_argb", g.la, e.la);
				if (g.lv !== e.lv) report_mismatch("lower_visible", g.lv, e.lv);
				if (g.lastc !== e.lastc) report_mismatch("last_column", g.lastc, e.lastc);
			end
			columns_seen++;
		end
		out_stall <= ($urandom_range(99) < out_idle_pct);
	end

	// drive one item and wait for its transfer; random gaps ahead of it
	task automatic send_item(input stim_row_t r);
		column_t c;
		while ($urandom_range(99) < in_idle_pct || hold_sender) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		opcode <= r.op;
		start_x <= r.sx; start_y <= r.sy; end_x <= r.ex; end_y <= r.ey;
		line_color <= r.color;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		// transfer took place at this edge; in_valid drops with the next idle
		if (rasterize_item(r, c)) begin
			if (r.has_fixed && c !== r.fixed)
				report_mismatch("typed-in column", c.ua, r.fixed.ua);
			pending_columns.push_back(r.has_fixed ? r.fixed : c);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (pending_columns.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
		longint v;
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		v = val > MAX_SCREEN_DIM ? MAX_SCREEN_DIM : val;
		if (idx == REG_SCREEN_WIDTH) p_width = v;
		else if (idx == REG_SCREEN_HEIGHT) p_height = v;
		@(posedge clk);
	endtask

	function automatic stim_row_t mk(logic op, longint sx, longint sy, longint ex,
			longint ey, logic [23:0] color);
		stim_row_t r;
		r.op = op; r.sx = sx; r.sy = sy; r.ex = ex; r.ey = ey; r.color = color;
		r.has_fixed = 0; r.fixed = '0;
		return r;
	endfunction

	function automatic logic signed [17:0] rnd_coord(int span);
		if ($urandom_range(9) == 0) return 18'($urandom);
		return 18'($signed($urandom_range(2 * span)) - span);
	endfunction

	stim_row_t directed[$];
	stim_row_t r;
	int n_sent, ncols;

	initial begin
		arst_n = 0;
		in_valid = 0; opcode = 0; start_x = 0; start_y = 0; end_x = 0; end_y = 0;
		line_color = 0; out_stall = 0; cfg_valid = 0; cfg_index = 0; cfg_data = 0;
		errors = 0; cycles = 0; columns_seen = 0; hold_sender = 0;
		in_idle_pct = 34; out_idle_pct = 34;
		p_active = 0; p_steep = 0; p_phase = 0; p_width = 640; p_height = 480;
		p_slope = 0; p_icept = 0; p_cursor = 0; p_limit = 0; p_color = 0;
		foreach (p_ep[i]) p_ep[i] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: next with no line, horizontal line at origin (typed in)
		directed.push_back(mk(OP_NEXT, 0, 0, 0, 0, 0));
		r = mk(OP_LOAD, 0, 0, 64, 0, 24'hFFFFFF);
		directed.push_back(r);
		// first endpoint column: gap 1/2 at x=0,y=0 -> upper half intensity
		r = mk(OP_NEXT, 0, 0, 0, 0, 0);
		r.has_fixed = 1;
		r.fixed = '{12'd320, 12'd240, 32'hFF7F7F7F, 1'b1,
			12'd320, 12'd239, 32'hFF000000, 1'b1, 1'b0};
		directed.push_back(r);
		directed.push_back(mk(OP_NEXT, 0, 0, 0, 0, 0));
		directed.push_back(mk(OP_NEXT, 0, 0, 0, 0, 0));
		// extremes, steep, single column, reversed order, drop mid-line
		directed.push_back(mk(OP_LOAD, -131072, -131072, 131071, 131071, 24'hFF0000));
		directed.push_back(mk(OP_NEXT, 0, 0, 0, 0, 0));
		directed.push_back(mk(OP_NEXT, 0, 0, 0, 0, 0));
		directed.push_back(mk(OP_LOAD, 10, 5, 10, 300, 24'h00FF00));
		for (int i = 0; i < 5; i++) directed.push_back(mk(OP_NEXT, 0, 0, 0, 0, 0));
		directed.push_back(mk(OP_LOAD, 131071, -100, -131072, 90, 24'h0000FF));
		directed.push_back(mk(OP_NEXT, -1, -1, -1, -1, 24'hFFFFFF));
		directed.push_back(mk(OP_LOAD, 33, 17, 40, -20, 24'h123456));
		for (int i = 0; i < 4; i++) directed.push_back(mk(OP_NEXT, 0, 0, 0, 0, 0));
		directed.push_back(mk(OP_LOAD, -32, 32, 96, -3000, 24'hABCDEF));
		for (int i = 0; i < 3; i++) directed.push_back(mk(OP_NEXT, 0, 0, 0, 0, 0));
		foreach (directed[i]) send_item(directed[i]);
		wait_drained();

		// random phases over several screen settings, extremes included
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(REG_SCREEN_WIDTH, 13'd1); write_reg(REG_SCREEN_HEIGHT, 13'd1); end
				1: begin write_reg(REG_SCREEN_WIDTH, 13'h1FFF); write_reg(REG_SCREEN_HEIGHT, 13'd4096); end
				2: begin write_reg(REG_SCREEN_WIDTH, 13'd0); write_reg(REG_SCREEN_HEIGHT, 13'd0); end
				3: begin write_reg(2'd3, 13'd5); write_reg(2'd2, 13'd9);
					write_reg(REG_SCREEN_WIDTH, 13'd64); write_reg(REG_SCREEN_HEIGHT, 13'd48); end
				default: begin
					write_reg(REG_SCREEN_WIDTH, 13'($urandom));
					write_reg(REG_SCREEN_HEIGHT, 13'($urandom));
				end
			endcase
			// phase 4 runs without any idling on either side
			in_idle_pct = ph == 4 ? 0 : 34;
			out_idle_pct = ph == 4 ? 0 : 34;
			n_sent = 0;
			while (n_sent < N_RANDOM / 6) begin
				int span;
				span = $urandom_range(3) == 0 ? 131071 : 1500;
				send_item(mk(OP_LOAD, rnd_coord(span), rnd_coord(span), rnd_coord(span),
					rnd_coord(span), 24'($urandom)));
				n_sent++;
				ncols = $urandom_range(9) == 0 ? $urandom_range(3) : $urandom_range(2, 40);
				for (int k = 0; k < ncols; k++) begin
					// loaded-looking payload on a next request is ignored
					send_item(mk(OP_NEXT, rnd_coord(131071), rnd_coord(131071),
						rnd_coord(131071), rnd_coord(131071), 24'($urandom)));
					n_sent++;
				end
				// in phase 1, pause the sender until everything has drained while fewer than 60 items are sent
				if (n_sent < 60 && ph == 1) begin
					hold_sender = 1;
					in_valid <= 0;
					while (pending_columns.size() != 0) @(posedge clk);
					hold_sender = 0;
				end
			end
			wait_drained();
		end

		$display("covered %0d columns over directed rows and six screen settings",
			columns_seen);
		$display("including clipped, steep, reversed, dropped and single-column lines");
		if (errors == 0 && pending_columns.size() == 0)
			$display("tb_antialiased_line_rasterizer_core: PASS");
		else
			$display("tb_antialiased_line_rasterizer_core: FAIL");
		$finish;
	end

endmodule
